// File: sv/wavhp_pkg.sv
// ============================================================================
// wavhp_pkg
// Shared types and constants of the RIFF/WAVE PCM header parser.
// ============================================================================
package wavhp_pkg;

    // Tags and limits of the container format.
    localparam logic [31:0] TAG_RIFF       = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE       = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT        = 32'h666d_7420;
    localparam logic [31:0] TAG_DATA       = 32'h6461_7461;
    localparam logic [31:0] FMT_BODY_BYTES = 32'd16;
    localparam logic [31:0] FMT_EXT_BASE   = 32'd18;
    localparam logic [31:0] PCM_CODE       = 32'd1;
    localparam logic [31:0] RATE_MIN       = 32'd100;
    localparam logic [31:0] RATE_MAX       = 32'd96000;

    // Width of the field counter: it holds a padded chunk size up to 2^32.
    localparam int CNT_W = 33;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOT_RIFF = 3'd1,
        ST_NOT_WAVE = 3'd2,
        ST_NOT_PCM  = 3'd3,
        ST_BAD_EXT  = 3'd4,
        ST_BAD_META = 3'd5,
        ST_TRUNC    = 3'd6,
        ST_RANGE    = 3'd7
    } status_t;

    // Parse phases.
    typedef enum logic [3:0] {
        PH_RIFF    = 4'd0,
        PH_RSIZE   = 4'd1,
        PH_WAVE    = 4'd2,
        PH_FHDR    = 4'd3,
        PH_FSKIP   = 4'd4,
        PH_FMT     = 4'd5,
        PH_EXTLEN  = 4'd6,
        PH_EXTSKIP = 4'd7,
        PH_DHDR    = 4'd8,
        PH_DSKIP   = 4'd9,
        PH_DONE    = 4'd10
    } phase_t;

    // One input item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    // One result item.
    typedef struct packed {
        status_t     status;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [15:0] block_align;
        logic [15:0] bits_per_sample;
        logic        format_unsigned8;
        logic [31:0] data_offset;
        logic [31:0] data_length;
    } result_t;

endpackage

// File: sv/wav_header_parser_top.sv
// ============================================================================
// wav_header_parser_top
// RIFF/WAVE PCM header parser: takes a file one byte per item and gives one
// result item per stream with the format fields and the data chunk place.
// ============================================================================
//
//   Channel | Ports                         | Direction | Item
//   --------+-------------------------------+-----------+---------------------
//   s_      | s_valid/s_ready, 2 fields     | in        | one file byte
//   m_      | m_valid/m_ready, 8 fields     | out       | one parse result
//
// One byte item is taken every cycle while no stalled result holds input. A
// byte sits in the input register, is parsed in one step against the parse
// state, and its result, if any, lands in the output register at the edge
// where the core takes the byte; m_valid comes from the output register.
// Reset is synchronous, active low, and returns to waiting for the RIFF tag.
// A stalled result blocks input only when the next byte also yields a result.
// ============================================================================
module wav_header_parser_top #(
    parameter int POSITION_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_channel_count,
    output logic [31:0] m_sample_rate,
    output logic [15:0] m_block_align,
    output logic [15:0] m_bits_per_sample,
    output logic        m_format_unsigned8,
    output logic [31:0] m_data_offset,
    output logic [31:0] m_data_length
);
    import wavhp_pkg::*;

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     item_take;
    logic     out_free;
    logic     res_load;
    result_t  res;
    result_t  m_res;

    assign s_item.data_byte = s_data_byte;
    assign s_item.last_byte = s_last_byte;

    // Input register.
    wavhp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // Parse state and byte step.
    wavhp_parse_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .out_free   (out_free),
        .res_load   (res_load),
        .res        (res)
    );

    // Output register.
    wavhp_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res_load (res_load),
        .res      (res),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (m_res)
    );

    assign m_status           = m_res.status;
    assign m_channel_count    = m_res.channel_count;
    assign m_sample_rate      = m_res.sample_rate;
    assign m_block_align      = m_res.block_align;
    assign m_bits_per_sample  = m_res.bits_per_sample;
    assign m_format_unsigned8 = m_res.format_unsigned8;
    assign m_data_offset      = m_res.data_offset;
    assign m_data_length      = m_res.data_length;

endmodule

// File: sv/wavhp_in_reg.sv
// ============================================================================
// wavhp_in_reg
// Input register: holds one accepted byte item until the parse core takes it.
// ============================================================================
module wavhp_in_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  wavhp_pkg::in_item_t s_item,
    output logic                item_valid,
    output wavhp_pkg::in_item_t item,
    input  logic                item_take
);
    import wavhp_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    // The register is free when empty or when the core takes its item now.
    assign s_ready    = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// File: sv/wavhp_parse_core.sv
// ============================================================================
// wavhp_parse_core
// Parse state and the one-byte step of the RIFF/WAVE header parser.
// ============================================================================
module wavhp_parse_core #(
    parameter int POSITION_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    input  wavhp_pkg::in_item_t item,
    output logic                item_take,
    input  logic                out_free,
    output logic                res_load,
    output wavhp_pkg::result_t  res
);
    import wavhp_pkg::*;

    localparam int PW = POSITION_BITS + 1;
    localparam int CW = (PW > 33) ? PW : 33;

    // Parse state.
    phase_t             phase_reg,  phase_next;
    logic [CNT_W-1:0]   fcnt_reg,   fcnt_next;
    logic [31:0]        shift_reg,  shift_next;
    logic [31:0]        tag_reg,    tag_next;
    logic [31:0]        fsize_reg,  fsize_next;
    logic [15:0]        ch_reg,     ch_next;
    logic [31:0]        rate_reg,   rate_next;
    logic [15:0]        align_reg,  align_next;
    logic [15:0]        bits_reg,   bits_next;
    logic [PW-1:0]      pos_reg,    pos_next;
    logic               given_reg,  given_next;

    // Step result.
    logic               step_res;
    status_t            step_status;
    logic [CW-1:0]      pos_ext;
    logic               pos_over;
    logic [31:0]        ext_len;
    logic [7:0]         b;

    // Metadata check on the format values.
    function automatic logic meta_ok(input logic [31:0] rate, input logic [15:0] ch,
                                     input logic [15:0] align, input logic [15:0] bits);
        logic ok;
        ok = (rate >= RATE_MIN) && (rate <= RATE_MAX);
        ok = ok && (ch == 16'd1 || ch == 16'd2);
        ok = ok && (align == 16'd1 || align == 16'd2 || align == 16'd4);
        ok = ok && (bits == 16'd8 || bits == 16'd16);
        return ok;
    endfunction

    assign b = item.data_byte;

    // One byte step: next state and whether it yields a result.
    always_comb begin
        phase_next  = phase_reg;
        fcnt_next   = fcnt_reg;
        shift_next  = shift_reg;
        tag_next    = tag_reg;
        fsize_next  = fsize_reg;
        ch_next     = ch_reg;
        rate_next   = rate_reg;
        align_next  = align_reg;
        bits_next   = bits_reg;
        pos_next    = pos_reg;
        given_next  = given_reg;
        step_res    = 1'b0;
        step_status = ST_OK;
        pos_ext     = '0;
        pos_over    = 1'b0;
        ext_len     = '0;

        if (!given_reg) begin
            if (!pos_reg[POSITION_BITS]) begin
                pos_next = pos_reg + PW'(1);
            end
            pos_ext  = CW'(pos_next);
            pos_over = pos_next[POSITION_BITS] || (pos_ext > CW'(33'h0_FFFF_FFFF));

            unique case (phase_reg)
                PH_RIFF, PH_RSIZE, PH_WAVE: begin
                    tag_next  = {tag_reg[23:0], b};
                    fcnt_next = fcnt_reg + CNT_W'(1);
                    if (fcnt_next == CNT_W'(4)) begin
                        fcnt_next = '0;
                        if (phase_reg == PH_RIFF) begin
                            if (tag_next != TAG_RIFF) begin
                                step_res    = 1'b1;
                                step_status = ST_NOT_RIFF;
                            end else begin
                                phase_next = PH_RSIZE;
                            end
                        end else if (phase_reg == PH_RSIZE) begin
                            phase_next = PH_WAVE;
                        end else if (tag_next != TAG_WAVE) begin
                            step_res    = 1'b1;
                            step_status = ST_NOT_WAVE;
                        end else begin
                            phase_next = PH_FHDR;
                        end
                    end
                end

                PH_FHDR, PH_DHDR: begin
                    // Tag bytes first (big endian), then the size (little endian).
                    if (fcnt_reg < CNT_W'(4)) begin
                        tag_next = {tag_reg[23:0], b};
                    end else begin
                        shift_next = {b, shift_reg[31:8]};
                    end
                    fcnt_next = fcnt_reg + CNT_W'(1);
                    if (fcnt_next == CNT_W'(8)) begin
                        if (phase_reg == PH_FHDR && tag_next == TAG_FMT) begin
                            fsize_next = shift_next;
                            tag_next   = '0;
                            ch_next    = '0;
                            rate_next  = '0;
                            align_next = '0;
                            bits_next  = '0;
                            phase_next = PH_FMT;
                            fcnt_next  = '0;
                        end else if (phase_reg == PH_DHDR && tag_next == TAG_DATA) begin
                            step_res    = 1'b1;
                            step_status = pos_over ? ST_RANGE : ST_OK;
                        end else begin
                            // Skip the chunk body, padded to even length.
                            fcnt_next = {1'b0, shift_next} + {32'd0, shift_next[0]};
                            if (fcnt_next != '0) begin
                                phase_next = (phase_reg == PH_FHDR) ? PH_FSKIP : PH_DSKIP;
                            end
                        end
                    end
                end

                PH_FSKIP, PH_DSKIP: begin
                    if (fcnt_reg != '0) begin
                        fcnt_next = fcnt_reg - CNT_W'(1);
                    end
                    if (fcnt_next == '0) begin
                        phase_next = (phase_reg == PH_FSKIP) ? PH_FHDR : PH_DHDR;
                    end
                end

                PH_FMT: begin
                    // Little-endian fields of the 16-byte format body.
                    unique case (fcnt_reg[3:0])
                        4'd0:    tag_next[7:0]    = b;
                        4'd1:    tag_next[15:8]   = b;
                        4'd2:    ch_next[7:0]     = b;
                        4'd3:    ch_next[15:8]    = b;
                        4'd4:    rate_next[7:0]   = b;
                        4'd5:    rate_next[15:8]  = b;
                        4'd6:    rate_next[23:16] = b;
                        4'd7:    rate_next[31:24] = b;
                        4'd12:   align_next[7:0]  = b;
                        4'd13:   align_next[15:8] = b;
                        4'd14:   bits_next[7:0]   = b;
                        4'd15:   bits_next[15:8]  = b;
                        default: ;
                    endcase
                    fcnt_next = fcnt_reg + CNT_W'(1);
                    if (fcnt_next == CNT_W'(FMT_BODY_BYTES)) begin
                        if (tag_next != PCM_CODE) begin
                            step_res    = 1'b1;
                            step_status = ST_NOT_PCM;
                        end else if (fsize_reg > FMT_BODY_BYTES) begin
                            phase_next = PH_EXTLEN;
                            fcnt_next  = '0;
                            shift_next = '0;
                        end else if (!meta_ok(rate_next, ch_next, align_next, bits_next)) begin
                            step_res    = 1'b1;
                            step_status = ST_BAD_META;
                        end else begin
                            phase_next = PH_DHDR;
                            fcnt_next  = '0;
                        end
                    end
                end

                PH_EXTLEN: begin
                    if (fcnt_reg == '0) begin
                        shift_next = {24'd0, b};
                    end else begin
                        shift_next = shift_reg | {16'd0, b, 8'd0};
                    end
                    fcnt_next = fcnt_reg + CNT_W'(1);
                    if (fcnt_next == CNT_W'(2)) begin
                        ext_len = {16'd0, shift_next[15:0]};
                        if ((fsize_reg - FMT_EXT_BASE) != ext_len) begin
                            step_res    = 1'b1;
                            step_status = ST_BAD_EXT;
                        end else begin
                            fcnt_next = {1'b0, ext_len} + {32'd0, ext_len[0]};
                            if (fcnt_next != '0) begin
                                phase_next = PH_EXTSKIP;
                            end else if (!meta_ok(rate_reg, ch_reg, align_reg, bits_reg)) begin
                                step_res    = 1'b1;
                                step_status = ST_BAD_META;
                            end else begin
                                phase_next = PH_DHDR;
                            end
                        end
                    end
                end

                PH_EXTSKIP: begin
                    if (fcnt_reg != '0) begin
                        fcnt_next = fcnt_reg - CNT_W'(1);
                    end
                    if (fcnt_next == '0) begin
                        if (!meta_ok(rate_reg, ch_reg, align_reg, bits_reg)) begin
                            step_res    = 1'b1;
                            step_status = ST_BAD_META;
                        end else begin
                            phase_next = PH_DHDR;
                        end
                    end
                end

                default: ;
            endcase

            if (step_res) begin
                given_next = 1'b1;
                phase_next = PH_DONE;
            end
        end

        // The last byte of a stream reports truncation if no result was given yet, and rearms.
        if (item.last_byte) begin
            if (!given_reg && !step_res) begin
                step_res    = 1'b1;
                step_status = ST_TRUNC;
            end
            phase_next = PH_RIFF;
            fcnt_next  = '0;
            shift_next = '0;
            tag_next   = '0;
            fsize_next = '0;
            ch_next    = '0;
            rate_next  = '0;
            align_next = '0;
            bits_next  = '0;
            pos_next   = '0;
            given_next = 1'b0;
        end
    end

    // Result fields: all zero except status unless the parse succeeded.
    // Success only comes from the data header, where the format values are
    // settled and the final size byte completes the length.
    always_comb begin
        res        = '0;
        res.status = step_status;
        if (step_status == ST_OK) begin
            res.channel_count    = ch_reg;
            res.sample_rate      = rate_reg;
            res.block_align      = align_reg;
            res.bits_per_sample  = bits_reg;
            res.format_unsigned8 = (bits_reg == 16'd8);
            res.data_offset      = 32'(pos_ext);
            res.data_length      = {b, shift_reg[31:8]};
        end
    end

    // A byte that yields a result needs a free output register.
    assign item_take = item_valid && (out_free || !step_res);
    assign res_load  = item_take && step_res;

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_RIFF;
            fcnt_reg  <= '0;
            shift_reg <= '0;
            tag_reg   <= '0;
            fsize_reg <= '0;
            ch_reg    <= '0;
            rate_reg  <= '0;
            align_reg <= '0;
            bits_reg  <= '0;
            pos_reg   <= '0;
            given_reg <= 1'b0;
        end else if (item_take) begin
            phase_reg <= phase_next;
            fcnt_reg  <= fcnt_next;
            shift_reg <= shift_next;
            tag_reg   <= tag_next;
            fsize_reg <= fsize_next;
            ch_reg    <= ch_next;
            rate_reg  <= rate_next;
            align_reg <= align_next;
            bits_reg  <= bits_next;
            pos_reg   <= pos_next;
            given_reg <= given_next;
        end
    end

endmodule

// File: sv/wavhp_out_reg.sv
// ============================================================================
// wavhp_out_reg
// Output register: holds one result item until the consumer takes it.
// ============================================================================
module wavhp_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               res_load,
    input  wavhp_pkg::result_t res,
    output logic               out_free,
    output logic               m_valid,
    input  logic               m_ready,
    output wavhp_pkg::result_t m_res
);
    import wavhp_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_res    = res_reg;

    // Valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_reg <= res;
        end
    end

endmodule

// File: sv/wavhp_checker.sv
// ============================================================================
// wavhp_checker
// Port-level checks on the result channel of the header parser.
// ============================================================================
module wavhp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [15:0] m_channel_count,
    input logic [31:0] m_sample_rate,
    input logic [15:0] m_block_align,
    input logic [15:0] m_bits_per_sample,
    input logic        m_format_unsigned8,
    input logic [31:0] m_data_offset,
    input logic [31:0] m_data_length
);
    import wavhp_pkg::*;

    // A stalled result item holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_data_offset))
        else $error("stalled result item changed");

    // A failed parse reports only its status.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_channel_count == 16'd0 && m_sample_rate == 32'd0
            && m_block_align == 16'd0 && m_bits_per_sample == 16'd0
            && m_data_offset == 32'd0 && m_data_length == 32'd0 && !m_format_unsigned8)
        else $error("error result carries nonzero fields");

    // A successful parse carries metadata that passed the check.
    a_ok_meta: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_OK |-> (m_channel_count == 16'd1 || m_channel_count == 16'd2)
            && (m_bits_per_sample == 16'd8 || m_bits_per_sample == 16'd16)
            && m_format_unsigned8 == (m_bits_per_sample == 16'd8)
            && m_sample_rate >= RATE_MIN && m_sample_rate <= RATE_MAX)
        else $error("success result with bad metadata");

    // The data offset lies past the RIFF, WAVE, fmt and data headers.
    a_ok_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_OK |-> m_data_offset >= 32'd44)
        else $error("data offset too small");

    // No result right after reset.
    a_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !m_valid)
        else $error("result valid right after reset");

endmodule

bind wav_header_parser_top wavhp_checker u_wavhp_checker (.*);
